/* rtl/wpm_pkg.sv */
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the wildcard pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  localparam int unsigned MaxPatternDef = 16;

  localparam logic [7:0] StarByte  = 8'h2A;
  localparam logic [7:0] QmarkByte = 8'h3F;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEXT   = 2'd2,
    FUNC_FINISH = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_OVERFLOW     = 2'd1,
    ERR_LATE_PATTERN = 2'd2
  } err_e;

  // Broadcast from the top level to every cell for the accepted beat.
  typedef struct packed {
    logic clear;
    logic load;
    logic text;
    logic rearm;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/wpm_in_if.sv */
// ----------------------------------------------------------------------------
// wpm_in_if
// Request channel: operation code and symbol byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] symbol;

  modport source (output valid, output func, output symbol, input ready);
  modport sink   (input valid, input func, input symbol, output ready);
endinterface

`default_nettype wire

/* rtl/wpm_out_if.sv */
// ----------------------------------------------------------------------------
// wpm_out_if
// Result channel: match flag and error code.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpm_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [1:0] error_code;

  modport source (output valid, output matched, output error_code, input ready);
  modport sink   (input valid, input matched, input error_code, output ready);
endinterface

`default_nettype wire

/* rtl/wpm_cell.sv */
// ----------------------------------------------------------------------------
// wpm_cell
// One pattern position: stores its pattern byte, its match bit and its
// initial-column bit, and computes the next match bit from its left neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wpm_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                active_i,
  input  wire logic                write_i,
  input  wire logic [7:0]          symbol_i,
  input  wire logic                prev_match_i,
  input  wire logic                prev_next_i,
  input  wire logic                prev_init_i,
  output logic                     match_o,
  output logic                     next_o,
  output logic                     init_o
);
  import wpm_pkg::*;

  logic [7:0] pat_q;
  logic       match_q, match_d;
  logic       init_q, init_d;
  logic       new_init;

  assign new_init = prev_init_i && (symbol_i == StarByte);

  // Exact or '?' takes the diagonal; '*' ripples from the left or holds.
  always_comb begin
    if ((pat_q == symbol_i) || (pat_q == QmarkByte)) begin
      next_o = prev_match_i;
    end else if (pat_q == StarByte) begin
      next_o = prev_next_i | match_q;
    end else begin
      next_o = 1'b0;
    end
    if (!active_i) begin
      next_o = 1'b0;
    end
  end

  always_comb begin
    match_d = match_q;
    init_d  = init_q;
    if (ctrl_i.clear) begin
      match_d = 1'b0;
      init_d  = 1'b0;
    end else if (ctrl_i.load) begin
      init_d  = write_i ? new_init : init_q;
      match_d = init_d;
    end else if (ctrl_i.text) begin
      match_d = next_o;
    end else if (ctrl_i.rearm) begin
      match_d = init_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      init_q  <= 1'b0;
    end else begin
      match_q <= match_d;
      init_q  <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_i) begin
      pat_q <= symbol_i;
    end
  end

  assign match_o = match_q;
  assign init_o  = init_q;

endmodule

`default_nettype wire

/* rtl/wildcard_pattern_match_top.sv */
// ----------------------------------------------------------------------------
// wildcard_pattern_match_top
// Wildcard matcher built as a row of pattern cells.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock: clear, append a pattern byte,
// stream a text byte, or finish. A finish beat loads the result register,
// whose beat is offered on the next cycle. Input is stalled only while that
// result waits to be taken. The cycle time is set by the match bit rippling
// through a run of '*' cells across the MAX_PATTERN cells of the row. Errors
// are sticky until a clear beat, and a finish rearms the row for a new text
// against the same pattern.
`default_nettype none

module wildcard_pattern_match_top #(
  parameter int unsigned MAX_PATTERN = wpm_pkg::MaxPatternDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wpm_in_if.sink    in_i,
  wpm_out_if.source out_o
);
  import wpm_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);

  logic [LenW-1:0] len_q, len_d;
  logic            started_q, started_d;
  err_e            err_q, err_d;
  logic            match0_q, match0_d;
  logic            out_valid_q;
  logic            out_matched_q;
  err_e            out_err_q;

  logic            accept;
  func_e           func;
  logic            append_ok;
  cell_ctrl_t      ctrl;

  logic [MAX_PATTERN:0]   col;
  logic [MAX_PATTERN:0]   nxt;
  logic [MAX_PATTERN:0]   ini;
  logic [MAX_PATTERN-1:0] active;
  logic [MAX_PATTERN-1:0] write_en;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign func       = func_e'(in_i.func);
  assign append_ok  = accept && (func == FUNC_APPEND) && !started_q &&
                      (len_q < LenW'(MAX_PATTERN));

  always_comb begin
    ctrl.clear = accept && (func == FUNC_CLEAR);
    ctrl.load  = append_ok;
    ctrl.text  = accept && (func == FUNC_TEXT);
    ctrl.rearm = accept && (func == FUNC_FINISH);
  end

  assign col[0] = match0_q;
  assign nxt[0] = 1'b0;
  assign ini[0] = 1'b1;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    assign active[g]   = len_q > LenW'(g);
    assign write_en[g] = append_ok && (len_q == LenW'(g));

    wpm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .active_i     (active[g]),
      .write_i      (write_en[g]),
      .symbol_i     (in_i.symbol),
      .prev_match_i (col[g]),
      .prev_next_i  (nxt[g]),
      .prev_init_i  (ini[g]),
      .match_o      (col[g+1]),
      .next_o       (nxt[g+1]),
      .init_o       (ini[g+1])
    );
  end

  always_comb begin
    len_d     = len_q;
    started_d = started_q;
    err_d     = err_q;
    match0_d  = match0_q;
    if (accept) begin
      case (func)
        FUNC_CLEAR: begin
          len_d     = '0;
          started_d = 1'b0;
          err_d     = ERR_NONE;
          match0_d  = 1'b1;
        end
        FUNC_APPEND: begin
          if (started_q) begin
            if (err_q == ERR_NONE) err_d = ERR_LATE_PATTERN;
          end else if (!append_ok) begin
            if (err_q == ERR_NONE) err_d = ERR_OVERFLOW;
          end else begin
            len_d    = len_q + LenW'(1);
            match0_d = 1'b1;
          end
        end
        FUNC_TEXT: begin
          started_d = 1'b1;
          match0_d  = 1'b0;
        end
        FUNC_FINISH: begin
          started_d = 1'b0;
          match0_d  = 1'b1;
        end
        default: begin
          len_d = len_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      started_q   <= 1'b0;
      err_q       <= ERR_NONE;
      match0_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      len_q     <= len_d;
      started_q <= started_d;
      err_q     <= err_d;
      match0_q  <= match0_d;
      if (ctrl.rearm) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on finish, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (ctrl.rearm) begin
      out_matched_q <= (err_q == ERR_NONE) && col[len_q];
      out_err_q     <= err_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.matched    = out_matched_q;
  assign out_o.error_code = out_err_q;

endmodule

`default_nettype wire
